FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the UTF-8 decoder RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_SYNC(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    `ASSERT_SYNC(lbl, clk, rst_n, !(expr))

`endif

FILE: sv/u8dc_pkg.sv
// ---------------------------------------------------------------------------
// u8dc_pkg
// Types, constants and classification functions for the UTF-8 decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package u8dc_pkg;

    localparam int CP_W    = 21;
    localparam int WIDTH_W = 10;
    localparam int TDATA_W = 40;

    localparam logic [7:0] LEAD3_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD3_SEL  = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'h3F;

    localparam logic [WIDTH_W-1:0] W_NARROW = 10'd250;
    localparam logic [WIDTH_W-1:0] W_SPACE  = 10'd278;
    localparam logic [WIDTH_W-1:0] W_NORMAL = 10'd556;
    localparam logic [WIDTH_W-1:0] W_UPPER  = 10'd667;
    localparam logic [WIDTH_W-1:0] W_WIDE   = 10'd833;

    typedef struct packed {
        logic            have;
        logic [CP_W-1:0] cp;
        logic            last;
    } t_point;

    function automatic logic in_rng(input logic [CP_W-1:0] cp,
                                    input logic [CP_W-1:0] lo,
                                    input logic [CP_W-1:0] hi);
        return (cp >= lo) && (cp <= hi);
    endfunction

    function automatic logic cjk_break(input logic [CP_W-1:0] cp);
        return in_rng(cp, 21'h02E80, 21'h09FFF) ||
               in_rng(cp, 21'h0AC00, 21'h0D7AF) ||
               in_rng(cp, 21'h0F900, 21'h0FAFF) ||
               in_rng(cp, 21'h0FF00, 21'h0FF60) ||
               in_rng(cp, 21'h03000, 21'h0303F) ||
               in_rng(cp, 21'h20000, 21'h2FA1F);
    endfunction

    function automatic logic ascii_printable(input logic [CP_W-1:0] cp);
        return ((cp >= 21'h20) && (cp < 21'h7F)) || (cp == 21'h0A);
    endfunction

    function automatic logic [WIDTH_W-1:0] ascii_width(input logic [CP_W-1:0] cp);
        logic [7:0] c;
        logic [WIDTH_W-1:0] w;
        c = cp[7:0];
        if (cp >= 21'h80) begin
            w = '0;
        end else if (c == 8'h20) begin
            w = W_SPACE;
        end else if (c == 8'h69 || c == 8'h6C || c == 8'h6A || c == 8'h2E ||
                     c == 8'h2C || c == 8'h27 || c == 8'h3A || c == 8'h3B ||
                     c == 8'h7C || c == 8'h21) begin
            w = W_NARROW;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            w = W_UPPER;
        end else if (c == 8'h6D || c == 8'h77 || c == 8'h4D || c == 8'h57) begin
            w = W_WIDE;
        end else begin
            w = W_NORMAL;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: sv/u8dc_decode.sv
// ---------------------------------------------------------------------------
// u8dc_decode
// Byte-level UTF-8 sequence tracking with a registered decoded-point stage.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module u8dc_decode (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_last,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output u8dc_pkg::t_point      o_point
);

    logic [1:0]                  r_pending, n_pending;
    logic [u8dc_pkg::CP_W-1:0]   r_partial, n_partial;
    logic                        r_good, n_good;
    logic                        r_vld;
    u8dc_pkg::t_point            r_item, n_item;
    logic                        acc;
    logic                        emit;

    assign o_ready = !r_vld || i_ready;
    assign acc     = i_valid && o_ready;
    assign o_valid = r_vld;
    assign o_point = r_item;

    always_comb begin
        n_pending   = r_pending;
        n_partial   = r_partial;
        n_good      = r_good;
        n_item.have = 1'b0;
        n_item.cp   = '0;
        n_item.last = i_last;
        if (r_pending == 2'd0) begin
            if (!i_byte[7]) begin
                n_item.have = 1'b1;
                n_item.cp   = {13'd0, i_byte};
            end else if ((i_byte & u8dc_pkg::LEAD3_MASK) == u8dc_pkg::LEAD2_TAG) begin
                n_partial = {16'd0, i_byte[4:0]};
                n_pending = 2'd1;
                n_good    = 1'b1;
            end else if ((i_byte & u8dc_pkg::LEAD3_SEL) == u8dc_pkg::LEAD3_TAG) begin
                n_partial = {17'd0, i_byte[3:0]};
                n_pending = 2'd2;
                n_good    = 1'b1;
            end else if ((i_byte & u8dc_pkg::LEAD4_MASK) == u8dc_pkg::LEAD4_TAG) begin
                n_partial = {18'd0, i_byte[2:0]};
                n_pending = 2'd3;
                n_good    = 1'b1;
            end
        end else begin
            if (i_byte[7:6] != 2'b10) begin
                n_good = 1'b0;
            end
            n_partial = {r_partial[14:0], i_byte[5:0] & u8dc_pkg::CONT_MASK[5:0]};
            n_pending = r_pending - 2'd1;
            if (n_pending == 2'd0 && n_good) begin
                n_item.have = 1'b1;
                n_item.cp   = n_partial;
            end
        end
        if (i_last) begin
            n_pending = 2'd0;
            n_partial = '0;
            n_good    = 1'b1;
        end
    end

    assign emit = n_item.have || i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_partial <= '0;
            r_good    <= 1'b1;
            r_vld     <= 1'b0;
        end else begin
            if (acc) begin
                r_pending <= n_pending;
                r_partial <= n_partial;
                r_good    <= n_good;
            end
            if (acc && emit) begin
                r_vld <= 1'b1;
            end else if (i_ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && emit) begin
            r_item <= n_item;
        end
    end

    `ASSERT_SYNC(a_last_clears_state, i_clk, i_rst_n,
        (acc && i_last) |=> (r_pending == 2'd0 && r_good && r_partial == '0))
    `ASSERT_NEVER(a_no_empty_word, i_clk, i_rst_n,
        r_vld && !r_item.have && !r_item.last)
    `ASSERT_SYNC(a_point_stalls, i_clk, i_rst_n,
        (r_vld && !i_ready) |=> (r_vld && $stable(r_item)))

endmodule

`default_nettype wire

FILE: sv/u8dc_classify.sv
// ---------------------------------------------------------------------------
// u8dc_classify
// Classifies a decoded code point and holds the result in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module u8dc_classify (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire u8dc_pkg::t_point              i_point,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [u8dc_pkg::TDATA_W-1:0]       o_data,
    output logic                               o_point_valid,
    output logic                               o_last
);

    logic                            r_vld;
    logic                            r_pv;
    logic [u8dc_pkg::CP_W-1:0]       r_cp;
    logic                            r_brk;
    logic                            r_rnd;
    logic [u8dc_pkg::WIDTH_W-1:0]    r_wid;
    logic                            r_last;
    logic                            acc;

    assign o_ready = !r_vld || i_ready;
    assign acc     = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (acc) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_pv   <= i_point.have;
            r_last <= i_point.last;
            if (i_point.have) begin
                r_cp  <= i_point.cp;
                r_brk <= u8dc_pkg::cjk_break(i_point.cp);
                r_rnd <= u8dc_pkg::ascii_printable(i_point.cp);
                r_wid <= u8dc_pkg::ascii_width(i_point.cp);
            end else begin
                r_cp  <= '0;
                r_brk <= 1'b0;
                r_rnd <= 1'b0;
                r_wid <= '0;
            end
        end
    end

    assign o_valid       = r_vld;
    assign o_point_valid = r_pv;
    assign o_last        = r_last;
    assign o_data        = {7'd0, r_wid, r_rnd, r_brk, r_cp};

    `ASSERT_NEVER(a_empty_word_zero, i_clk, i_rst_n,
        r_vld && !r_pv && (r_cp != '0 || r_wid != '0 || r_brk || r_rnd))
    `ASSERT_NEVER(a_classes_exclusive, i_clk, i_rst_n,
        r_vld && r_brk && (r_rnd || r_wid != '0))

endmodule

`default_nettype wire

FILE: sv/utf8_decode_and_classify_top.sv
// ---------------------------------------------------------------------------
// utf8_decode_and_classify_top
// UTF-8 byte stream decoder that tags each code point with wrap and width data.
// ---------------------------------------------------------------------------
// A byte that completes a code point, or the final byte, is registered first
// in the decode stage and then in the classify stage, whose register drives
// the word on the master side.
// Throughput: one byte per cycle while words are taken; master back-pressure stalls the input.
// Reset: synchronous, active low; clears the sequence state and both
// stage valid flags, so no word is presented out of reset.
`default_nettype none

module utf8_decode_and_classify_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tlast,   // end_of_text
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,   // [20:0] code_point, [21] break_anywhere,
                                               // [22] renderable_ascii,
                                               // [32:23] glyph_width, [39:33] zero
    output logic             o_m_axis_tuser,   // point_valid
    output logic             o_m_axis_tlast    // stream_end
);

    logic             dec_valid;
    logic             cls_ready;
    u8dc_pkg::t_point dec_point;

    u8dc_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_valid (dec_valid),
        .i_ready (cls_ready),
        .o_point (dec_point)
    );

    u8dc_classify u_classify (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (dec_valid),
        .o_ready       (cls_ready),
        .i_point       (dec_point),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_data        (o_m_axis_tdata),
        .o_point_valid (o_m_axis_tuser),
        .o_last        (o_m_axis_tlast)
    );

endmodule

`default_nettype wire
